/* sv/lut3dcg_pkg.sv */
// Package for the 3D color grading block.
// Holds grid, address and level constants; no dependencies.
package lut3dcg_pkg;

  localparam int unsigned GridBits  = 5;
  localparam int unsigned AddrW     = 3 * GridBits;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned FracW     = 3;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned OutDataW  = 24;
  localparam int unsigned FieldEntW = 12;

  localparam logic [GridBits-1:0] GridTop     = 5'd31;
  localparam logic [GridBits-1:0] GridTopCell = 5'd30;
  localparam logic [ChanW-1:0]    LevelMax    = 8'hFF;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_LOAD  = 1'b1
  } action_e;

endpackage

/* sv/lut3dcg_table.sv */
// Color table memory: one write port and two registered read ports.
// Depends on lut3dcg_pkg for the address width.
module lut3dcg_table #(
  parameter int unsigned WIDTH = 36
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [lut3dcg_pkg::AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]          wr_data_i,
  input  logic                      rd_en_i,
  input  logic [lut3dcg_pkg::AddrW-1:0] rd_lo_addr_i,
  input  logic [lut3dcg_pkg::AddrW-1:0] rd_hi_addr_i,
  output logic [WIDTH-1:0]          rd_lo_data_o,
  output logic [WIDTH-1:0]          rd_hi_data_o
);
  import lut3dcg_pkg::*;

  localparam int unsigned Depth = 2 ** AddrW;

  logic [WIDTH-1:0] mem_q [Depth];
  logic [WIDTH-1:0] rd_lo_q;
  logic [WIDTH-1:0] rd_hi_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_lo_q <= mem_q[rd_lo_addr_i];
      rd_hi_q <= mem_q[rd_hi_addr_i];
    end
  end

  assign rd_lo_data_o = rd_lo_q;
  assign rd_hi_data_o = rd_hi_q;

endmodule

/* sv/lut3dcg_lerp.sv */
// One channel of diagonal interpolation: weight stage, then sum, shift and clamp.
// Depends on lut3dcg_pkg for fraction and level widths.
module lut3dcg_lerp #(
  parameter int unsigned ENTRY_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [ENTRY_BITS-1:0]          start_i,
  input  logic [ENTRY_BITS-1:0]          end_i,
  input  logic [lut3dcg_pkg::FracW-1:0]  frac_i,
  output logic [lut3dcg_pkg::ChanW-1:0]  level_o
);
  import lut3dcg_pkg::*;

  localparam int unsigned WeightW = FracW + 1;
  localparam int unsigned ProdW   = ENTRY_BITS + WeightW;
  localparam int unsigned SumW    = ProdW + 1;
  localparam int unsigned ShiftW  = FracW + 4;
  localparam int unsigned TopBit  = ShiftW + ChanW;
  localparam int unsigned ExtW    = (SumW > TopBit) ? SumW : TopBit + 1;
  localparam logic [WeightW-1:0] CellSteps = WeightW'(2 ** FracW);

  logic [WeightW-1:0] w_start;
  logic [ProdW-1:0]   prod_s_d, prod_s_q;
  logic [ProdW-1:0]   prod_e_d, prod_e_q;
  logic [SumW-1:0]    sum;
  logic [ExtW-1:0]    sum_ext;
  logic [ChanW-1:0]   level_d, level_q;

  assign w_start  = CellSteps - {1'b0, frac_i};
  assign prod_s_d = ProdW'(w_start * start_i);
  assign prod_e_d = ProdW'({1'b0, frac_i} * end_i);

  assign sum     = {1'b0, prod_s_q} + {1'b0, prod_e_q};
  assign sum_ext = ExtW'(sum);
  assign level_d = (|sum_ext[ExtW-1:TopBit]) ? LevelMax : sum_ext[TopBit-1:ShiftW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_s_q <= prod_s_d;
      prod_e_q <= prod_e_d;
      level_q  <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

/* sv/lut3d_diagonal_color_grade.sv */
// Top level of the 3D color grading block: address generation, table, three lerp lanes.
// Depends on lut3dcg_pkg, lut3dcg_table and lut3dcg_lerp.
//
//  port group  dir  payload
//  s_axis      in   tuser = action, tdata = pixel rgb, entry index, entry rgb
//  m_axis      out  tdata = graded rgb
//
// An input beat reaches the output through the table read, weight and sum registers.
// One beat is taken every cycle while the output is not stalled; the pipeline advances as a whole.
// A stalled output holds every stage and s_axis_tready falls with it.
// Reset clears the valid bits and the loaded flag; table contents are undefined until written.
module lut3d_diagonal_color_grade #(
  parameter int unsigned ENTRY_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // action
  input  logic                              s_axis_tuser,
  // pixel_red, pixel_green, pixel_blue, entry_index, entry_red, entry_green,
  // entry_blue, zero fill
  input  logic [lut3dcg_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // graded_red, graded_green, graded_blue
  output logic [lut3dcg_pkg::OutDataW-1:0]  m_axis_tdata
);
  import lut3dcg_pkg::*;

  localparam int unsigned EntryW = 3 * ENTRY_BITS;

  logic                adv;
  logic                accept;
  logic                is_load;
  logic                loaded_d, loaded_q;
  logic                v0_q, v1_q, v2_q;
  logic [ChanW-1:0]    chan [3];
  logic [GridBits-1:0] idx [3];
  logic [GridBits-1:0] idx_hi [3];
  logic [FracW-1:0]    frac_q [3];
  logic [AddrW-1:0]    lo_addr, hi_addr;
  logic [AddrW-1:0]    wr_addr;
  logic [EntryW-1:0]   wr_data;
  logic [EntryW-1:0]   rd_lo, rd_hi;
  logic [ChanW-1:0]    level [3];

  assign adv           = !v2_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign is_load       = (action_e'(s_axis_tuser) == ACT_LOAD);
  assign loaded_d      = loaded_q || (accept && is_load);

  assign chan[0] = s_axis_tdata[7:0];
  assign chan[1] = s_axis_tdata[15:8];
  assign chan[2] = s_axis_tdata[23:16];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      idx[i]    = (chan[i][ChanW-1:FracW] == GridTop) ? GridTopCell
                                                      : chan[i][ChanW-1:FracW];
      idx_hi[i] = idx[i] + GridBits'(1);
    end
  end

  assign lo_addr = {idx[2], idx[1], idx[0]};
  assign hi_addr = {idx_hi[2], idx_hi[1], idx_hi[0]};
  assign wr_addr = s_axis_tdata[38:24];
  assign wr_data = {ENTRY_BITS'(s_axis_tdata[74:63]),
                    ENTRY_BITS'(s_axis_tdata[62:51]),
                    ENTRY_BITS'(s_axis_tdata[50:39])};

  lut3dcg_table #(
    .WIDTH(EntryW)
  ) u_table (
    .clk_i       (clk_i),
    .wr_en_i     (accept && is_load),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (adv),
    .rd_lo_addr_i(lo_addr),
    .rd_hi_addr_i(hi_addr),
    .rd_lo_data_o(rd_lo),
    .rd_hi_data_o(rd_hi)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        frac_q[i] <= chan[i][FracW-1:0];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    lut3dcg_lerp #(
      .ENTRY_BITS(ENTRY_BITS)
    ) u_lerp (
      .clk_i  (clk_i),
      .en_i   (adv),
      .start_i(rd_lo[g*ENTRY_BITS +: ENTRY_BITS]),
      .end_i  (rd_hi[g*ENTRY_BITS +: ENTRY_BITS]),
      .frac_i (frac_q[g]),
      .level_o(level[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      loaded_q <= loaded_d;
      if (adv) begin
        v0_q <= accept && !is_load && loaded_q;
        v1_q <= v0_q;
        v2_q <= v1_q;
      end
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {level[2], level[1], level[0]};

  a_loaded_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(loaded_q))
    else $error("table loaded flag dropped");

  a_no_result_unloaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q |-> loaded_q)
    else $error("pixel entered pipeline before any load");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !v0_q)
    else $error("load beat produced a pipeline valid");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v0_q) && $stable(v1_q) && $stable(v2_q))
    else $error("pipeline moved during stall");

endmodule

/* tb/lut3dcg_grade_checker.sv */
`timescale 1ns / 100ps
// Checker for lut3d_diagonal_color_grade: mirrors the color table from load beats,
// predicts each graded pixel and compares it against the m_axis beats in order.
// Depends on lut3dcg_pkg only.
module lut3dcg_grade_checker
  import lut3dcg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // action
  input  logic                s_axis_tuser,
  // pixel_red, pixel_green, pixel_blue, entry_index, entry_red, entry_green,
  // entry_blue, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // graded_red, graded_green, graded_blue
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int                  mismatches_o,
  output int                  pending_o,
  output int                  graded_beats_o,
  output int                  entry_beats_o
);

  localparam int unsigned EntryLsb  = 3 * ChanW;
  localparam int unsigned LevelLsb  = EntryLsb + AddrW;
  localparam int unsigned CellSteps = 1 << FracW;
  localparam int unsigned WeightSh  = FracW + 4;

  typedef logic [FieldEntW-1:0] level_t;

  level_t              lut_mem [3][1 << AddrW];
  logic                lut_loaded;
  logic [OutDataW-1:0] graded_q [$];
  int                  fault_count;
  int                  graded_seen;
  int                  entry_seen;
  string               chan_name [3] = '{"graded_red", "graded_green", "graded_blue"};

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0d want %0d", $realtime, what, got, want);
    fault_count++;
  endtask

  function automatic logic [OutDataW-1:0] grade_pixel(input logic [3*ChanW-1:0] rgb);
    logic [GridBits-1:0] grid_idx [3];
    logic [AddrW-1:0]    lo_addr;
    logic [AddrW-1:0]    hi_addr;
    logic [FracW-1:0]    frac;
    int unsigned         acc;
    logic [OutDataW-1:0] graded;
    for (int ch = 0; ch < 3; ch++) begin
      grid_idx[ch] = rgb[ChanW*ch+FracW +: GridBits];
      if (grid_idx[ch] == GridTop) begin
        grid_idx[ch] = GridTopCell;
      end
    end
    lo_addr = {grid_idx[2], grid_idx[1], grid_idx[0]};
    hi_addr = {grid_idx[2] + 5'd1, grid_idx[1] + 5'd1, grid_idx[0] + 5'd1};
    for (int ch = 0; ch < 3; ch++) begin
      frac = rgb[ChanW*ch +: FracW];
      acc  = ((CellSteps - frac) * lut_mem[ch][lo_addr] + frac * lut_mem[ch][hi_addr])
             >> WeightSh;
      if (acc > LevelMax) begin
        acc = LevelMax;
      end
      graded[ChanW*ch +: ChanW] = acc[ChanW-1:0];
    end
    return graded;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OutDataW-1:0] want;
    if (!rst_ni) begin
      graded_q.delete();
      lut_loaded  = 1'b0;
      fault_count = 0;
      graded_seen = 0;
      entry_seen  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (graded_q.size() == 0) begin
          report_mismatch("unexpected graded beat", int'(m_axis_tdata), 0);
        end else begin
          want = graded_q.pop_front();
          for (int ch = 0; ch < 3; ch++) begin
            if (m_axis_tdata[ChanW*ch +: ChanW] !== want[ChanW*ch +: ChanW]) begin
              report_mismatch(chan_name[ch], int'(m_axis_tdata[ChanW*ch +: ChanW]),
                              int'(want[ChanW*ch +: ChanW]));
            end
          end
        end
        graded_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == ACT_LOAD) begin
          for (int ch = 0; ch < 3; ch++) begin
            lut_mem[ch][s_axis_tdata[EntryLsb +: AddrW]] =
              s_axis_tdata[LevelLsb + FieldEntW*ch +: FieldEntW];
          end
          lut_loaded = 1'b1;
          entry_seen++;
        end else if (lut_loaded) begin
          graded_q.push_back(grade_pixel(s_axis_tdata[3*ChanW-1:0]));
        end
      end
    end
    pending_o      <= graded_q.size();
    mismatches_o   <= fault_count;
    graded_beats_o <= graded_seen;
    entry_beats_o  <= entry_seen;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top of the lut3d_diagonal_color_grade testbench: clock, reset, table loads and
// pixel stimulus with random idling on both streams. Depends on lut3dcg_pkg, the DUT
// and lut3dcg_grade_checker.
module testbench;
  import lut3dcg_pkg::*;

  localparam int unsigned RandomItems = 1950;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldAfter   = 300;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned EntryLsb    = 3 * ChanW;
  localparam logic [FieldEntW-1:0] LevelMaxRaw = '1;
  localparam logic [AddrW-1:0] DiagStep =
    AddrW'((1 << (2 * GridBits)) + (1 << GridBits) + 1);

  typedef logic [FieldEntW-1:0] level_t;

  logic                clk_i;
  logic                rst_ni   = 1'b0;
  logic                s_valid  = 1'b0;
  logic                s_ready;
  action_e             s_user   = ACT_PIXEL;
  logic [InDataW-1:0]  s_data   = '0;
  logic                m_valid;
  logic                m_ready  = 1'b0;
  logic [OutDataW-1:0] m_data;

  int mismatches;
  int pending;
  int graded_beats;
  int entry_beats;
  int sent_items = 0;
  int cycles     = 0;

  bit               written [1 << AddrW];
  logic [AddrW-1:0] ready_cells [$];

  lut3d_diagonal_color_grade dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tuser  (s_user),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  lut3dcg_grade_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_valid),
    .s_axis_tready  (s_ready),
    .s_axis_tuser   (s_user),
    .s_axis_tdata   (s_data),
    .m_axis_tvalid  (m_valid),
    .m_axis_tready  (m_ready),
    .m_axis_tdata   (m_data),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .graded_beats_o (graded_beats),
    .entry_beats_o  (entry_beats)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("lut3d_diagonal_color_grade regression: fail");
      $finish;
    end
  end

  function automatic bit quiet_stretch(input int n);
    return (n % 160) >= 120;
  endfunction

  function automatic level_t rand_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LevelMaxRaw;
      default: return level_t'($urandom_range(0, LevelMaxRaw));
    endcase
  endfunction

  function automatic logic [AddrW-1:0] rand_cell();
    logic [GridBits-1:0] r, g, b;
    r = GridBits'($urandom_range(0, GridTopCell));
    g = GridBits'($urandom_range(0, GridTopCell));
    b = GridBits'($urandom_range(0, GridTopCell));
    return {b, g, r};
  endfunction

  function automatic logic [InDataW-1:0] pixel_word(input logic [ChanW-1:0] r, g, b);
    logic [InDataW-1:0] word;
    word = '0;
    word[3*ChanW-1:0] = {b, g, r};
    return word;
  endfunction

  function automatic logic [InDataW-1:0] entry_word(input logic [AddrW-1:0] addr,
                                                    input level_t r, g, b);
    logic [InDataW-1:0] word;
    word = '0;
    word[EntryLsb +: AddrW + 3*FieldEntW] = {b, g, r, addr};
    return word;
  endfunction

  task automatic send_beat(input action_e act, input logic [InDataW-1:0] word);
    int gap;
    gap = quiet_stretch(sent_items) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= word;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sent_items++;
  endtask

  // Write one entry and register any diagonal pair it completes.
  task automatic load_entry(input logic [AddrW-1:0] addr, input level_t r, g, b);
    send_beat(ACT_LOAD, entry_word(addr, r, g, b));
    written[addr] = 1'b1;
    if (addr[4:0] != GridTop && addr[9:5] != GridTop && addr[14:10] != GridTop &&
        written[addr + DiagStep]) begin
      ready_cells.push_back(addr);
    end
    if (addr[4:0] != '0 && addr[9:5] != '0 && addr[14:10] != '0 &&
        written[addr - DiagStep]) begin
      ready_cells.push_back(addr - DiagStep);
    end
  endtask

  // Grade a pixel that lands in a cube whose two diagonal entries are written.
  task automatic send_pixel(input logic [AddrW-1:0] corner);
    logic [ChanW-1:0]    c [3];
    logic [GridBits-1:0] idx;
    for (int ch = 0; ch < 3; ch++) begin
      idx   = corner[GridBits*ch +: GridBits];
      c[ch] = {idx, 3'b000} + ChanW'($urandom_range(0, idx == GridTopCell ? 15 : 7));
    end
    send_beat(ACT_PIXEL, pixel_word(c[0], c[1], c[2]));
  endtask

  function automatic logic [AddrW-1:0] any_ready_cell();
    return ready_cells[$urandom_range(0, ready_cells.size() - 1)];
  endfunction

  initial begin
    int stall;
    int beats = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (beats == HoldAfter) begin
        stall = HoldCycles;
      end else begin
        stall = quiet_stretch(beats) ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_valid) @(posedge clk_i);
      beats++;
    end
  end

  initial begin
    logic [AddrW-1:0] corner;
    int               kind;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // drop: pixels ahead of any load
    send_beat(ACT_PIXEL, pixel_word(8'h00, 8'h00, 8'h00));
    send_beat(ACT_PIXEL, pixel_word(8'hFF, 8'hFF, 8'hFF));
    send_beat(ACT_PIXEL, pixel_word(8'h55, 8'hAA, 8'h5A));

    // bottom cube, mixed extremes
    load_entry('0, LevelMaxRaw, '0, 12'd2048);
    load_entry(DiagStep, '0, LevelMaxRaw, 12'd2048);
    send_beat(ACT_PIXEL, pixel_word(8'd0, 8'd0, 8'd0));
    send_beat(ACT_PIXEL, pixel_word(8'd7, 8'd7, 8'd7));
    send_beat(ACT_PIXEL, pixel_word(8'd3, 8'd5, 8'd1));

    // top cube: index 31 folds onto 30
    load_entry({GridTopCell, GridTopCell, GridTopCell}, '0, '0, '0);
    load_entry({GridTop, GridTop, GridTop}, LevelMaxRaw, LevelMaxRaw, LevelMaxRaw);
    send_beat(ACT_PIXEL, pixel_word(8'd255, 8'd255, 8'd255));
    send_beat(ACT_PIXEL, pixel_word(8'd240, 8'd247, 8'd255));
    send_beat(ACT_PIXEL, pixel_word(8'd248, 8'd250, 8'd252));

    // overwrite then read back at once
    load_entry('0, LevelMaxRaw, LevelMaxRaw, LevelMaxRaw);
    send_beat(ACT_PIXEL, pixel_word(8'd0, 8'd0, 8'd0));
    send_beat(ACT_PIXEL, pixel_word(8'd7, 8'd0, 8'd4));

    while (sent_items < RandomItems + 15) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        corner = rand_cell();
        load_entry(corner, rand_level(), rand_level(), rand_level());
        load_entry(corner + DiagStep, rand_level(), rand_level(), rand_level());
        repeat ($urandom_range(1, 6)) begin
          send_pixel(($urandom_range(0, 9) < 7) ? corner : any_ready_cell());
        end
      end else if (kind < 9) begin
        load_entry(AddrW'($urandom_range(0, (1 << AddrW) - 1)), rand_level(),
                   rand_level(), rand_level());
      end else begin
        load_entry(rand_cell(), rand_level(), rand_level(), rand_level());
        repeat ($urandom_range(1, 3)) send_pixel(any_ready_cell());
      end
    end
    s_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d input beats: %0d table writes, %0d graded pixels checked",
             sent_items, entry_beats, graded_beats);
    $display("included unloaded pixels, top-cell folding and a %0d-cycle output stall",
             HoldCycles);
    if (mismatches == 0) begin
      $display("lut3d_diagonal_color_grade regression: pass");
    end else begin
      $display("lut3d_diagonal_color_grade regression: fail");
    end
    $finish;
  end

endmodule
